[sv/pra_pkg.sv]
package pra_pkg;

   // Table and page geometry
   localparam int RANGES     = 64;
   localparam int PAGE_BYTES = 4096;
   localparam int ADDR_W     = 48;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W      = $clog2(RANGES);
   localparam int CNT_W      = $clog2(RANGES + 1);
   localparam int PCNT_W     = 36;

   // Request codes
   localparam logic [1:0] FN_ALLOC = 2'd0;
   localparam logic [1:0] FN_FREE  = 2'd1;
   localparam logic [1:0] FN_QUERY = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;

   typedef logic [PAGE_W-1:0] page_type;

   // One table entry: half-open page run [low, high) and its kind
   typedef struct packed {
      page_type low;
      page_type high;
      logic     kind;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

[sv/pra_ram.sv]
module pra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/page_range_allocator_top.sv]
// Page range allocator.
// Requests are taken on start while busy is low; func selects allocate, free
// or query of the highest free address. Heap bounds and the internal limit are
// written via the csr_ port, by the user only while idle; the block does not
// enforce it. Each request yields exactly one result, shown for one cycle
// with rsp_valid; the receiver cannot stall it, so none is ever held back.
// The used-range table lives in two banks of synchronous RAM. A request scans
// the active bank one entry per cycle (a first-fit allocate scans twice: once
// to find the gap, once to classify the entries it touches), then an edit
// copies the table into the other bank with the changed runs spliced in, one
// entry per cycle, and the banks swap.
// Requests that fail their early checks finish without any table access. One
// request is in work at a time, so the read port of the active bank sets the
// throughput.
// Reset empties the table and clears the page and internal byte counters and
// the registers; no clearing pass over the RAM is needed.
module page_range_allocator_top
   import pra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [ADDR_W-1:0] req_size,
   input  logic              req_internal_kind,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_result_addr,
   output logic [PCNT_W-1:0] rsp_pages_in_use,
   output logic [ADDR_W-1:0] rsp_internal_in_use,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_FIT, S_QUERY, S_CLASS, S_CLEND, S_COPY
   } state_type;

   localparam logic [1:0] CSR_BOTTOM = 2'd0;
   localparam logic [1:0] CSR_TOP    = 2'd1;
   localparam logic [1:0] CSR_LIMIT  = 2'd2;

   localparam logic [1:0] SRC_MEM = 2'd0;
   localparam logic [1:0] SRC_E0  = 2'd1;
   localparam logic [1:0] SRC_E1  = 2'd2;

   state_type         state_ff;
   logic [1:0]        func_ff;
   logic              kind_ff;
   logic              size_zero_ff;
   logic              misalign_ff;
   page_type          a_ff;
   logic [PAGE_W:0]   n_ff;
   page_type          top_ff;
   page_type          above_ff;
   logic              found_ff;
   logic              stop_ff;
   logic              vld_ff;
   logic [CNT_W-1:0]  issue_ff;
   page_type          nb_ff;
   page_type          nt_ff;
   page_type          freed_ff;
   logic              fail_ff;
   logic              mixed_ff;
   logic [CNT_W-1:0]  pre_ff;
   logic [CNT_W-1:0]  hit_ff;
   page_type          first_high_ff;
   logic              first_kind_ff;
   page_type          last_low_ff;
   entry_type         ent0_ff;
   entry_type         ent1_ff;
   logic [CNT_W-1:0]  rs_ff;
   logic [CNT_W-1:0]  re_ff;
   logic [1:0]        p_ff;
   logic [CNT_W-1:0]  newcnt_ff;
   logic [CNT_W-1:0]  dst_ff;
   logic              wr_vld_ff;
   logic [IDX_W-1:0]  wr_addr_ff;
   logic [1:0]        wr_src_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              bank_ff;
   logic [PCNT_W-1:0] pages_ff;
   logic [ADDR_W-1:0] used_ff;
   logic [ADDR_W-1:0] bottom_ff;
   logic [ADDR_W-1:0] top_reg_ff;
   logic [ADDR_W-1:0] limit_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_res_ff;

   logic [ENTRY_W-1:0] rdata0, rdata1, wdata;
   entry_type          rd_ent, wr_ent;
   logic [IDX_W-1:0]   rd_addr;
   page_type           hb, ht;
   logic [ADDR_W:0]    size_sum;
   logic [PAGE_W:0]    n_calc;
   logic [PAGE_W:0]    top_full;
   logic [ADDR_W-1:0]  room;
   logic [ADDR_W:0]    need_bytes;
   logic               fit_n_ok;
   page_type           gap_base;
   logic               fit_hit;
   logic               scanning, issue_go, proc, scan_end;
   logic               ov, touch, mg;
   page_type           part_lo, part_hi;
   page_type           got;
   logic               free_up, free_dn;
   logic [1:0]         free_p;
   logic [CNT_W:0]     free_newcnt;
   logic [ADDR_W-1:0]  freed_bytes;
   logic [CNT_W-1:0]   copy_off, copy_src;
   logic [1:0]         copy_kind;
   logic               copy_go, copy_end;

   // Page views of the heap bounds and the rounded request
   assign hb         = bottom_ff[ADDR_W-1:PAGE_SHIFT];
   assign ht         = top_reg_ff[ADDR_W-1:PAGE_SHIFT];
   assign size_sum   = {1'b0, req_size} + (ADDR_W+1)'(PAGE_BYTES - 1);
   assign n_calc     = size_sum[ADDR_W:PAGE_SHIFT];
   assign top_full   = {1'b0, a_ff} + n_ff;
   assign room       = (limit_ff > used_ff) ? (limit_ff - used_ff) : '0;
   assign need_bytes = {n_ff, {PAGE_SHIFT{1'b0}}};

   // Entry read from the active bank
   assign rd_ent = bank_ff ? entry_type'(rdata1) : entry_type'(rdata0);

   // Table scan sequencing: one read issued per cycle, data in the next cycle
   assign scanning = (state_ff == S_FIT) || (state_ff == S_QUERY) || (state_ff == S_CLASS);
   assign issue_go = scanning && !stop_ff && (issue_ff != count_ff);
   assign proc     = vld_ff && !stop_ff;
   assign scan_end = stop_ff || ((issue_ff == count_ff) && !vld_ff);

   // First-fit gap test against the run below the current gap top
   assign fit_n_ok = n_ff <= {1'b0, above_ff};
   assign gap_base = above_ff - n_ff[PAGE_W-1:0];
   assign fit_hit  = fit_n_ok && (rd_ent.high < gap_base);

   // Overlap and merge classification of one entry against [a, top)
   assign ov      = (rd_ent.low < top_ff) && (rd_ent.high > a_ff);
   assign touch   = (rd_ent.low == top_ff) || (rd_ent.high == a_ff);
   assign mg      = ov || (touch && (rd_ent.kind == kind_ff));
   assign part_lo = (rd_ent.low > a_ff) ? rd_ent.low : a_ff;
   assign part_hi = (rd_ent.high < top_ff) ? rd_ent.high : top_ff;

   // Outcome of the classification pass
   assign got         = (nt_ff - nb_ff) - freed_ff;
   assign free_up     = first_high_ff > top_ff;
   assign free_dn     = last_low_ff < a_ff;
   assign free_p      = {1'b0, free_up} + {1'b0, free_dn};
   assign free_newcnt = {1'b0, count_ff} - {1'b0, hit_ff} + (CNT_W+1)'(free_p);
   assign freed_bytes = {freed_ff, {PAGE_SHIFT{1'b0}}};

   // Copy pass: destination slot to source slot or spliced entry
   always_comb begin
      copy_off  = dst_ff - rs_ff;
      copy_src  = dst_ff;
      copy_kind = SRC_MEM;
      if (dst_ff >= rs_ff) begin
         if (copy_off < CNT_W'(p_ff)) begin
            copy_kind = (copy_off == '0) ? SRC_E0 : SRC_E1;
         end else begin
            copy_src = copy_off - CNT_W'(p_ff) + re_ff;
         end
      end
   end

   assign copy_go  = (state_ff == S_COPY) && (dst_ff != newcnt_ff);
   assign copy_end = (state_ff == S_COPY) && (dst_ff == newcnt_ff) && !wr_vld_ff;
   assign rd_addr  = (state_ff == S_COPY) ? copy_src[IDX_W-1:0] : issue_ff[IDX_W-1:0];

   always_comb begin
      case (wr_src_ff)
         SRC_E0:  wr_ent = ent0_ff;
         SRC_E1:  wr_ent = ent1_ff;
         default: wr_ent = rd_ent;
      endcase
   end
   assign wdata = wr_ent;

   // Two table banks: read the active one, rebuild into the other
   pra_ram #(.WIDTH(ENTRY_W), .DEPTH(RANGES)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_vld_ff && bank_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wdata),
      .rd_addr (rd_addr),
      .rd_data (rdata0)
   );

   pra_ram #(.WIDTH(ENTRY_W), .DEPTH(RANGES)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_vld_ff && !bank_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wdata),
      .rd_addr (rd_addr),
      .rd_data (rdata1)
   );

   // Control sequencer, counters and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         pages_ff     <= '0;
         used_ff      <= '0;
         bottom_ff    <= '0;
         top_reg_ff   <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         issue_ff     <= '0;
         wr_vld_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         // Register writes
         if (csr_we) begin
            case (csr_index)
               CSR_BOTTOM: bottom_ff  <= csr_wdata;
               CSR_TOP:    top_reg_ff <= csr_wdata;
               CSR_LIMIT:  limit_ff   <= csr_wdata;
               default: ;
            endcase
         end

         // Scan read issue
         if (scanning) begin
            vld_ff <= issue_go;
            if (issue_go) begin
               issue_ff <= issue_ff + 1'b1;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff       <= req_func;
                  kind_ff       <= req_internal_kind;
                  size_zero_ff  <= (req_size == '0);
                  misalign_ff   <= |req_addr[PAGE_SHIFT-1:0];
                  a_ff          <= req_addr[ADDR_W-1:PAGE_SHIFT];
                  n_ff          <= n_calc;
                  found_ff      <= 1'b0;
                  vld_ff        <= 1'b0;
                  stop_ff       <= 1'b0;
                  issue_ff      <= '0;
                  freed_ff      <= '0;
                  fail_ff       <= 1'b0;
                  mixed_ff      <= 1'b0;
                  pre_ff        <= '0;
                  hit_ff        <= '0;
                  state_ff      <= S_CHECK;
               end
            end

            // Checks that need no table access
            S_CHECK: begin
               rsp_res_ff <= '0;
               case (func_ff)
                  FN_ALLOC: begin
                     if (size_zero_ff) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= STAT_INVALID;
                        state_ff      <= S_IDLE;
                     end else if (kind_ff && (need_bytes > {1'b0, room})) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= STAT_NOSPACE;
                        state_ff      <= S_IDLE;
                     end else if (a_ff != '0) begin
                        if ((a_ff < hb) || (top_full > {1'b0, ht})) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= STAT_INVALID;
                           state_ff      <= S_IDLE;
                        end else begin
                           top_ff   <= top_full[PAGE_W-1:0];
                           nb_ff    <= a_ff;
                           nt_ff    <= top_full[PAGE_W-1:0];
                           state_ff <= S_CLASS;
                        end
                     end else begin
                        above_ff <= ht;
                        state_ff <= S_FIT;
                     end
                  end
                  FN_FREE: begin
                     if (size_zero_ff) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= STAT_NOSPACE;
                        state_ff      <= S_IDLE;
                     end else if (misalign_ff || (a_ff < hb) || (top_full > {1'b0, ht})) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= STAT_INVALID;
                        state_ff      <= S_IDLE;
                     end else begin
                        top_ff   <= top_full[PAGE_W-1:0];
                        state_ff <= S_CLASS;
                     end
                  end
                  FN_QUERY: begin
                     above_ff <= ht;
                     state_ff <= S_QUERY;
                  end
                  default: begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_INVALID;
                     state_ff      <= S_IDLE;
                  end
               endcase
            end

            // Top-down walk for the first gap that fits
            S_FIT: begin
               if (proc) begin
                  if (fit_hit) begin
                     found_ff <= 1'b1;
                     stop_ff  <= 1'b1;
                     a_ff     <= gap_base;
                     top_ff   <= above_ff;
                     nb_ff    <= gap_base;
                     nt_ff    <= above_ff;
                  end else begin
                     above_ff <= rd_ent.low;
                  end
               end
               if (scan_end) begin
                  issue_ff <= '0;
                  vld_ff   <= 1'b0;
                  stop_ff  <= 1'b0;
                  if (found_ff) begin
                     state_ff <= S_CLASS;
                  end else if (fit_n_ok && (hb < gap_base)) begin
                     a_ff     <= gap_base;
                     top_ff   <= above_ff;
                     nb_ff    <= gap_base;
                     nt_ff    <= above_ff;
                     state_ff <= S_CLASS;
                  end else begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_NOSPACE;
                     state_ff      <= S_IDLE;
                  end
               end
            end

            // Walk down from the heap top while runs touch the free address
            S_QUERY: begin
               if (proc) begin
                  if (rd_ent.high < above_ff) begin
                     stop_ff <= 1'b1;
                  end else begin
                     above_ff <= rd_ent.low;
                  end
               end
               if (scan_end) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= STAT_OK;
                  rsp_res_ff    <= {above_ff, {PAGE_SHIFT{1'b0}}};
                  state_ff      <= S_IDLE;
               end
            end

            // Classify every entry against the target run
            S_CLASS: begin
               if (proc) begin
                  if (func_ff == FN_ALLOC) begin
                     if (ov && (rd_ent.kind != kind_ff)) begin
                        fail_ff <= 1'b1;
                     end
                     if (mg) begin
                        hit_ff   <= hit_ff + 1'b1;
                        freed_ff <= freed_ff + (rd_ent.high - rd_ent.low);
                        if (rd_ent.low < nb_ff) begin
                           nb_ff <= rd_ent.low;
                        end
                        if (rd_ent.high > nt_ff) begin
                           nt_ff <= rd_ent.high;
                        end
                     end else if (rd_ent.low >= a_ff) begin
                        pre_ff <= pre_ff + 1'b1;
                     end
                  end else begin
                     if (ov) begin
                        if (hit_ff == '0) begin
                           first_high_ff <= rd_ent.high;
                           first_kind_ff <= rd_ent.kind;
                        end else if (rd_ent.kind != first_kind_ff) begin
                           mixed_ff <= 1'b1;
                        end
                        last_low_ff <= rd_ent.low;
                        hit_ff      <= hit_ff + 1'b1;
                        freed_ff    <= freed_ff + (part_hi - part_lo);
                     end else if (rd_ent.low >= top_ff) begin
                        pre_ff <= pre_ff + 1'b1;
                     end
                  end
               end
               if (scan_end) begin
                  state_ff <= S_CLEND;
               end
            end

            // Decide, update the counters and set up the splice
            S_CLEND: begin
               dst_ff    <= '0;
               wr_vld_ff <= 1'b0;
               rs_ff     <= pre_ff;
               re_ff     <= pre_ff + hit_ff;
               if (func_ff == FN_ALLOC) begin
                  if (fail_ff || (a_ff < hb) || (count_ff >= CNT_W'(RANGES))) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_NOSPACE;
                     rsp_res_ff    <= '0;
                     state_ff      <= S_IDLE;
                  end else begin
                     ent0_ff    <= '{low: nb_ff, high: nt_ff, kind: kind_ff};
                     p_ff       <= 2'd1;
                     newcnt_ff  <= count_ff - hit_ff + 1'b1;
                     pages_ff   <= pages_ff + PCNT_W'(got);
                     if (kind_ff) begin
                        used_ff <= used_ff + {got, {PAGE_SHIFT{1'b0}}};
                     end
                     rsp_res_ff <= {a_ff, {PAGE_SHIFT{1'b0}}};
                     state_ff   <= S_COPY;
                  end
               end else begin
                  rsp_res_ff <= '0;
                  if (hit_ff == '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_OK;
                     state_ff      <= S_IDLE;
                  end else if (mixed_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_INVALID;
                     state_ff      <= S_IDLE;
                  end else if (free_newcnt > (CNT_W+1)'(RANGES)) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_NOSPACE;
                     state_ff      <= S_IDLE;
                  end else begin
                     if (free_up) begin
                        ent0_ff <= '{low: top_ff, high: first_high_ff, kind: first_kind_ff};
                     end else begin
                        ent0_ff <= '{low: last_low_ff, high: a_ff, kind: first_kind_ff};
                     end
                     ent1_ff   <= '{low: last_low_ff, high: a_ff, kind: first_kind_ff};
                     p_ff      <= free_p;
                     newcnt_ff <= free_newcnt[CNT_W-1:0];
                     pages_ff  <= pages_ff - PCNT_W'(freed_ff);
                     if (first_kind_ff) begin
                        used_ff <= (used_ff >= freed_bytes) ? (used_ff - freed_bytes) : '0;
                     end
                     state_ff <= S_COPY;
                  end
               end
            end

            // Rebuild the table in the idle bank, then swap banks
            S_COPY: begin
               wr_vld_ff <= copy_go;
               if (copy_go) begin
                  dst_ff     <= dst_ff + 1'b1;
                  wr_addr_ff <= dst_ff[IDX_W-1:0];
                  wr_src_ff  <= copy_kind;
               end
               if (copy_end) begin
                  bank_ff       <= ~bank_ff;
                  count_ff      <= newcnt_ff;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= STAT_OK;
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_addr     = rsp_res_ff;
   assign rsp_pages_in_use    = pages_ff;
   assign rsp_internal_in_use = used_ff;

   // The table never holds more runs than it has slots.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(RANGES))
      else $error("range table count beyond capacity");

   // An accepted request makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   // A failed request reports no address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_result_addr == '0))
      else $error("failed request carries an address");

   // The copy pass never writes beyond the new table size.
   assert property (@(posedge clock) disable iff (reset)
      wr_vld_ff |-> ({1'b0, wr_addr_ff} < {1'b0, newcnt_ff}))
      else $error("table rebuild writes past the new end");

endmodule

[test/tb_page_range_allocator_top.sv]
`timescale 1ns / 1ps

module tb_page_range_allocator_top;
   import pra_pkg::*;

   typedef logic [63:0] u64;

   localparam logic [1:0] FN_UNKNOWN  = 2'd3;
   localparam logic [1:0] CSR_HEAP_BOTTOM = 2'd0;
   localparam logic [1:0] CSR_HEAP_TOP    = 2'd1;
   localparam logic [1:0] CSR_INT_LIMIT   = 2'd2;
   localparam u64 PB      = PAGE_BYTES;
   localparam u64 MASK36  = 64'hF_FFFF_FFFF;
   localparam u64 MASK48  = 64'hFFFF_FFFF_FFFF;
   localparam int IDLE_LIMIT = 4000;

   // One pending job: either a register write or a request
   typedef struct {
      bit              is_cfg;
      logic [1:0]      idx;
      logic [ADDR_W-1:0] data;
      logic [1:0]      fn;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] size;
      logic            kind;
   } job_t;

   typedef struct {
      logic [1:0]        status;
      logic [ADDR_W-1:0] addr;
      logic [PCNT_W-1:0] pages;
      logic [ADDR_W-1:0] intl;
   } outcome_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_func = FN_QUERY;
   logic [ADDR_W-1:0] req_addr = '0;
   logic [ADDR_W-1:0] req_size = '0;
   logic              req_internal_kind = 1'b0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [ADDR_W-1:0] rsp_result_addr;
   logic [PCNT_W-1:0] rsp_pages_in_use;
   logic [ADDR_W-1:0] rsp_internal_in_use;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = CSR_HEAP_BOTTOM;
   logic [ADDR_W-1:0] csr_wdata = '0;

   page_range_allocator_top dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow copy of the range table, counters and registers
   u64 run_lo [RANGES];
   u64 run_hi [RANGES];
   bit run_kind [RANGES];
   int run_count = 0;
   u64 pages_used = 0;
   u64 internal_used = 0;
   u64 heap_lo_reg = 0;
   u64 heap_hi_reg = 0;
   u64 internal_cap = 0;

   job_t     pending [$];
   outcome_t expected_results [$];
   job_t     in_flight;
   int       gap_left = 0;
   int       errors = 0;
   int       idle_cycles = 0;

   // Moves the tail of the table starting at from so that it starts at to.
   function automatic void move_tail(int from, int to);
      int n;
      n = run_count - from;
      if (n <= 0 || from == to) return;
      if (to > from) begin
         for (int i = n - 1; i >= 0; i--) begin
            run_lo[to + i] = run_lo[from + i];
            run_hi[to + i] = run_hi[from + i];
            run_kind[to + i] = run_kind[from + i];
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            run_lo[to + i] = run_lo[from + i];
            run_hi[to + i] = run_hi[from + i];
            run_kind[to + i] = run_kind[from + i];
         end
      end
   endfunction

   // Inserts pages [a, a+n) of kind k, merging with runs of the same kind.
   // ab is the index of the run just above, or -1.
   function automatic int insert_run(u64 a, u64 n, bit k, int ab);
      u64 top, nb, nt, freed, got;
      int i, j, m, newc;
      top = a + n;
      nb = a;
      nt = top;
      freed = 0;
      if (a < heap_lo_reg / PB) return STAT_NOSPACE;
      for (i = ab; i >= 0; i--) begin
         if (!(top > run_lo[i])) break;
         if (run_kind[i] != k) return STAT_NOSPACE;
      end
      for (i = ab + 1; i < run_count; i++) begin
         if (!(a < run_hi[i])) break;
         if (run_kind[i] != k) return STAT_NOSPACE;
      end
      if (run_count >= RANGES) return STAT_NOSPACE;
      for (j = ab; j >= 0; j--) begin
         if (!(run_lo[j] <= nt && run_kind[j] == k)) break;
         freed += run_hi[j] - run_lo[j];
         if (run_lo[j] < nb) nb = run_lo[j];
         if (run_hi[j] > nt) nt = run_hi[j];
      end
      for (m = ab + 1; m < run_count; m++) begin
         if (!(run_hi[m] >= nb && run_kind[m] == k)) break;
         freed += run_hi[m] - run_lo[m];
         if (run_lo[m] < nb) nb = run_lo[m];
         if (run_hi[m] > nt) nt = run_hi[m];
      end
      newc = run_count - (m - j - 1) + 1;
      move_tail(m, j + 2);
      run_count = newc;
      run_lo[j + 1] = nb;
      run_hi[j + 1] = nt;
      run_kind[j + 1] = k;
      got = (nt - nb) - freed;
      pages_used = (pages_used + got) & MASK36;
      if (k) internal_used = (internal_used + got * PB) & MASK48;
      return STAT_OK;
   endfunction

   function automatic int allocate_run(u64 addr, u64 size, bit k, output u64 base);
      u64 n, a, room, hb, ht, above;
      int i, ab, st;
      base = 0;
      ab = -1;
      hb = heap_lo_reg / PB;
      ht = heap_hi_reg / PB;
      if (size == 0) return STAT_INVALID;
      n = (size + PB - 1) / PB;
      a = addr / PB;
      room = internal_cap > internal_used ? internal_cap - internal_used : 0;
      if (k && n * PB > room) return STAT_NOSPACE;
      if (a != 0) begin
         if (a < hb || a + n > ht) return STAT_INVALID;
         for (i = 0; i < run_count; i++) begin
            if (!(run_lo[i] >= a)) break;
            ab = i;
         end
         st = insert_run(a, n, k, ab);
         if (st == STAT_OK) base = (a * PB) & MASK48;
         return st;
      end
      // Top-down first fit: the first gap with a page to spare below is used
      above = ht;
      for (i = 0; i < run_count; i++) begin
         if (n <= above && run_hi[i] < above - n) begin
            st = insert_run(above - n, n, k, ab);
            if (st == STAT_OK) base = ((above - n) * PB) & MASK48;
            return st;
         end
         ab = i;
         above = run_lo[i];
      end
      if (n <= above && hb < above - n) begin
         st = insert_run(above - n, n, k, ab);
         if (st == STAT_OK) base = ((above - n) * PB) & MASK48;
         return st;
      end
      return STAT_NOSPACE;
   endfunction

   function automatic int release_run(u64 addr, u64 size);
      u64 n, a, top, freed, lo, hi, up_lo, up_hi, dn_lo, dn_hi, b;
      int s, e, i, p;
      bit up, dn, k;
      freed = 0;
      p = 0;
      up = 0;
      dn = 0;
      up_lo = 0;
      up_hi = 0;
      dn_lo = 0;
      dn_hi = 0;
      if (size == 0) return STAT_NOSPACE;
      n = (size + PB - 1) / PB;
      if (addr % PB != 0) return STAT_INVALID;
      a = addr / PB;
      top = a + n;
      if (a < heap_lo_reg / PB || top > heap_hi_reg / PB) return STAT_INVALID;
      for (s = 0; s < run_count; s++) if (!(run_lo[s] >= top)) break;
      for (e = s; e < run_count; e++) if (!(run_hi[e] > a)) break;
      if (s == e) return STAT_OK;
      // Runs of both kinds under one free are refused before anything changes
      k = run_kind[s];
      for (i = s; i < e; i++) begin
         if (run_kind[i] != k) return STAT_INVALID;
         lo = run_lo[i] > a ? run_lo[i] : a;
         hi = run_hi[i] < top ? run_hi[i] : top;
         freed += hi - lo;
      end
      if (run_hi[s] > top) begin
         up = 1;
         up_lo = top;
         up_hi = run_hi[s];
         p++;
      end
      if (run_lo[e - 1] < a) begin
         dn = 1;
         dn_lo = run_lo[e - 1];
         dn_hi = a;
         p++;
      end
      if (run_count - (e - s) + p > RANGES) return STAT_NOSPACE;
      move_tail(e, s + p);
      run_count = run_count - (e - s) + p;
      i = s;
      if (up) begin
         run_lo[i] = up_lo;
         run_hi[i] = up_hi;
         run_kind[i] = k;
         i++;
      end
      if (dn) begin
         run_lo[i] = dn_lo;
         run_hi[i] = dn_hi;
         run_kind[i] = k;
      end
      pages_used = (pages_used - freed) & MASK36;
      if (k) begin
         b = freed * PB;
         internal_used = internal_used >= b ? internal_used - b : 0;
      end
      return STAT_OK;
   endfunction

   // Works out the result of one request and advances the shadow state.
   function automatic outcome_t serve_request(job_t j);
      outcome_t o;
      u64 base, x;
      int st;
      base = 0;
      case (j.fn)
         FN_ALLOC: begin
            st = allocate_run(u64'(j.addr), u64'(j.size), j.kind, base);
            if (st != STAT_OK) base = 0;
         end
         FN_FREE: begin
            st = release_run(u64'(j.addr), u64'(j.size));
         end
         FN_QUERY: begin
            x = heap_hi_reg / PB;
            for (int i = 0; i < run_count; i++) begin
               if (run_hi[i] < x) break;
               x = run_lo[i];
            end
            base = (x * PB) & MASK48;
            st = STAT_OK;
         end
         default: st = STAT_INVALID;
      endcase
      o.status = st[1:0];
      o.addr = base[ADDR_W-1:0];
      o.pages = pages_used[PCNT_W-1:0];
      o.intl = internal_used[ADDR_W-1:0];
      return o;
   endfunction

   function automatic void apply_register(logic [1:0] idx, logic [ADDR_W-1:0] v);
      case (idx)
         CSR_HEAP_BOTTOM: heap_lo_reg = u64'(v);
         CSR_HEAP_TOP:    heap_hi_reg = u64'(v);
         CSR_INT_LIMIT:   internal_cap = u64'(v);
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: presents requests on start and register writes when idle
   always @(posedge clock) begin
      logic nxt_start;
      logic nxt_we;
      job_t head;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         nxt_start = start;
         nxt_we = 1'b0;
         if (start && !busy) begin
            expected_results.push_back(serve_request(in_flight));
            nxt_start = 1'b0;
            gap_left = pick_gap();
         end
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() > 0) begin
               head = pending[0];
               if (head.is_cfg) begin
                  if (expected_results.size() == 0 && !rsp_valid && !busy) begin
                     nxt_we = 1'b1;
                     csr_index <= head.idx;
                     csr_wdata <= head.data;
                     apply_register(head.idx, head.data);
                     void'(pending.pop_front());
                  end
               end else begin
                  in_flight = head;
                  void'(pending.pop_front());
                  nxt_start = 1'b1;
                  req_func <= head.fn;
                  req_addr <= head.addr;
                  req_size <= head.size;
                  req_internal_kind <= head.kind;
               end
            end
         end
         start <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   // Monitor: every result transfer is checked against the oldest expectation
   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_result_addr !== want.addr) begin
               $error("result_addr: expected %h, got %h", want.addr, rsp_result_addr);
               errors++;
            end
            if (rsp_pages_in_use !== want.pages) begin
               $error("pages_in_use: expected %h, got %h", want.pages, rsp_pages_in_use);
               errors++;
            end
            if (rsp_internal_in_use !== want.intl) begin
               $error("internal_in_use: expected %h, got %h", want.intl,
                      rsp_internal_in_use);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void add_register(logic [1:0] idx, u64 v);
      job_t j;
      j = '{default: '0};
      j.is_cfg = 1;
      j.idx = idx;
      j.data = v[ADDR_W-1:0];
      pending.push_back(j);
   endfunction

   function automatic void add_request(logic [1:0] fn, u64 addr, u64 size, bit k);
      job_t j;
      j = '{default: '0};
      j.fn = fn;
      j.addr = addr[ADDR_W-1:0];
      j.size = size[ADDR_W-1:0];
      j.kind = k;
      pending.push_back(j);
   endfunction

   function automatic void add_heap(u64 lo, u64 hi, u64 cap);
      add_register(CSR_HEAP_BOTTOM, lo);
      add_register(CSR_HEAP_TOP, hi);
      add_register(CSR_INT_LIMIT, cap);
   endfunction

   function automatic u64 any48();
      return {$urandom, $urandom} & MASK48;
   endfunction

   // Random request aimed at the page window [lo, hi); span bounds how far
   // from either end of the window addresses fall.
   function automatic void add_random(u64 lo, u64 hi, u64 span);
      int r;
      u64 pg, size;
      bit k;
      r = $urandom_range(0, 99);
      pg = ($urandom_range(0, 1) == 1) ? lo + ($urandom % span) : hi - 1 - ($urandom % span);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24 * PAGE_BYTES)
                                         : $urandom_range(1, 6 * PAGE_BYTES);
      k = ($urandom_range(0, 9) < 3);
      if (r < 33) add_request(FN_ALLOC, 0, size, k);
      else if (r < 55) add_request(FN_ALLOC, pg * PB + $urandom_range(0, PAGE_BYTES - 1), size, k);
      else if (r < 80) add_request(FN_FREE, pg * PB, size, 0);
      else if (r < 88) add_request(FN_QUERY, any48(), any48(), $urandom_range(0, 1));
      else if (r < 95) add_request(2'($urandom_range(0, 3)), any48(), any48(), $urandom_range(0, 1));
      else if (r < 98) add_request(FN_FREE, pg * PB + $urandom_range(1, PAGE_BYTES - 1), size, k);
      else add_request(FN_UNKNOWN, any48(), any48(), k);
   endfunction

   initial begin
      u64 b, t, span;
      // Directed part on a small heap with unaligned register low bits
      add_heap(64'h10_0123, 64'h10_0000 + 80 * PB + 64'h7FF, 16 * PB);
      add_request(FN_QUERY, 0, 0, 0);
      add_request(FN_ALLOC, 0, 0, 0);
      add_request(FN_FREE, 64'h10_0000, 0, 0);
      add_request(FN_UNKNOWN, 0, PB, 0);
      add_request(FN_ALLOC, 0, 1, 0);
      add_request(FN_ALLOC, 0, PB + 1, 1);
      add_request(FN_ALLOC, 0, 20 * PB, 1);
      add_request(FN_ALLOC, 64'h0F_F000, PB, 0);
      add_request(FN_ALLOC, 64'h10_0000 + 78 * PB, 4 * PB, 0);
      add_request(FN_ALLOC, 64'h10_0000 + 76 * PB, 2 * PB, 0);
      add_request(FN_ALLOC, 64'h10_0000 + 77 * PB, PB, 1);
      add_request(FN_ALLOC, 64'h10_0000 + 10 * PB + 5, 4 * PB, 0);
      add_request(FN_ALLOC, 64'h10_0000 + 14 * PB, PB, 0);
      add_request(FN_FREE, 64'h10_0000 + 11 * PB + 8, PB, 0);
      add_request(FN_FREE, 64'h0F_F000, PB, 0);
      add_request(FN_FREE, 64'h10_0000 + 12 * PB, PB, 0);
      add_request(FN_FREE, 64'h10_0000 + 70 * PB, 10 * PB, 0);
      add_request(FN_FREE, 64'h10_0000 + 40 * PB, PB, 0);
      add_request(FN_QUERY, 0, 0, 0);
      add_request(FN_ALLOC, MASK48, MASK48, 1);
      add_request(FN_ALLOC, 0, MASK48, 0);
      add_request(FN_FREE, 64'hFFFF_FFFF_F000, MASK48, 0);
      add_request(FN_FREE, 64'h10_0000 + PB, 79 * PB, 0);

      // Fill the table: one wide run, then single pages until it is full
      add_heap(4 * PB, 200 * PB, MASK48);
      add_request(FN_ALLOC, 190 * PB, 3 * PB, 0);
      for (int i = 0; i < 63; i++) add_request(FN_ALLOC, (4 + 2 * i) * PB, PB, i % 2);
      add_request(FN_FREE, 191 * PB, PB, 0);
      add_request(FN_ALLOC, 150 * PB, PB, 0);
      add_request(FN_ALLOC, 0, PB, 0);
      add_request(FN_QUERY, 0, 0, 0);
      for (int i = 0; i < 63; i++) add_request(FN_FREE, (4 + 2 * i) * PB, PB, 0);
      add_request(FN_FREE, 4 * PB, 196 * PB, 0);

      // Random phases over a range of heap shapes and limits
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            3: begin
               b = 0;
               t = (MASK48 + 1) / PB - 1;
               add_heap(0, MASK48, MASK48);
            end
            5: begin
               b = 1;
               t = 40;
               add_heap(PB, 40 * PB, 0);
            end
            7: begin
               b = (MASK48 + 1) / PB - 300;
               t = (MASK48 + 1) / PB - 1;
               add_heap(b * PB, t * PB, $urandom_range(0, 60) * PB);
            end
            default: begin
               b = $urandom_range(1, 4096);
               t = b + $urandom_range(64, 200);
               add_heap(b * PB + $urandom_range(0, 1), t * PB,
                        $urandom_range(0, 40) * PB + $urandom_range(0, 7));
            end
         endcase
         span = (t - b > 200) ? 200 : t - b;
         for (int i = 0; i < 70; i++) add_random(b, t, span);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending.size() != 0 || expected_results.size() != 0 || start);
      repeat (250) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
